FILE: hdl/m4rm_pkg.sv
package m4rm_pkg;

    // Matrix order: four rows of B, four lanes in every row.
    localparam int DIM = 4;
    localparam int ROW_BITS = 2;

    // Width of every element port on the block.
    localparam int FIELD_BITS = 32;

    // Defaults for the top level parameters.
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_MUL  = 1'b1
    } t_action;

    // Control that travels with every beat down the cell chain.
    typedef struct packed {
        logic                valid;
        t_action             action;
        logic [ROW_BITS-1:0] row_sel;
    } t_ctrl;

endpackage

FILE: hdl/m4rm_cell.sv
// One row of B: multiply stage, then accumulate stage.
module m4rm_cell #(
    parameter int INDEX = 0,
    parameter int WORD_BITS = m4rm_pkg::WORD_BITS_DEF,
    localparam int ACC_BITS = 2 * WORD_BITS + 2,
    localparam int PROD_BITS = 2 * WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  m4rm_pkg::t_ctrl             i_ctrl,
    input  logic signed [WORD_BITS-1:0] i_row [m4rm_pkg::DIM],
    input  logic signed [ACC_BITS-1:0]  i_sum [m4rm_pkg::DIM],
    output m4rm_pkg::t_ctrl             o_ctrl,
    output logic signed [WORD_BITS-1:0] o_row [m4rm_pkg::DIM],
    output logic signed [ACC_BITS-1:0]  o_sum [m4rm_pkg::DIM]
);

    logic signed [WORD_BITS-1:0] r_b    [m4rm_pkg::DIM];
    logic signed [PROD_BITS-1:0] r_prod [m4rm_pkg::DIM];
    logic signed [WORD_BITS-1:0] r_row1 [m4rm_pkg::DIM];
    logic signed [ACC_BITS-1:0]  r_sum1 [m4rm_pkg::DIM];
    logic signed [WORD_BITS-1:0] r_row2 [m4rm_pkg::DIM];
    logic signed [ACC_BITS-1:0]  r_sum2 [m4rm_pkg::DIM];
    m4rm_pkg::t_ctrl             r_ctrl1;
    m4rm_pkg::t_ctrl             r_ctrl2;
    logic                        w_load;

    assign w_load = i_ctrl.valid && (i_ctrl.action == m4rm_pkg::ACT_LOAD)
                    && (i_ctrl.row_sel == m4rm_pkg::ROW_BITS'(INDEX));

    // Stored row and beat valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < m4rm_pkg::DIM; j++) begin
                r_b[j] <= '0;
            end
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
        end else if (i_en) begin
            if (w_load) begin
                r_b <= i_row;
            end
            r_ctrl1 <= i_ctrl;
            r_ctrl2 <= r_ctrl1;
        end
    end

    // Datapath: the row passes along, lane j adds a[INDEX] * B[INDEX][j].
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < m4rm_pkg::DIM; j++) begin
                r_prod[j] <= i_row[INDEX] * r_b[j];
                r_sum2[j] <= r_sum1[j] + ACC_BITS'(r_prod[j]);
            end
            r_row1 <= i_row;
            r_sum1 <= i_sum;
            r_row2 <= r_row1;
        end
    end

    assign o_ctrl = r_ctrl2;
    assign o_row  = r_row2;
    assign o_sum  = r_sum2;

endmodule

FILE: hdl/m4rm_sat.sv
// Arithmetic shift right by the fraction bits, then clamp to the word range.
module m4rm_sat #(
    parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m4rm_pkg::WORD_BITS_DEF,
    localparam int ACC_BITS = 2 * WORD_BITS + 2
) (
    input  logic signed [ACC_BITS-1:0]  i_acc,
    output logic signed [WORD_BITS-1:0] o_val,
    output logic                        o_clamp
);

    localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic signed [ACC_BITS-1:0]   w_shift;
    logic [ACC_BITS-WORD_BITS:0]  w_top;
    logic                         w_fits;

    assign w_shift = i_acc >>> FRAC_BITS;
    assign w_top   = w_shift[ACC_BITS-1:WORD_BITS-1];
    assign w_fits  = (&w_top) || !(|w_top);
    assign o_clamp = !w_fits;

    always_comb begin
        if (w_fits) begin
            o_val = w_shift[WORD_BITS-1:0];
        end else if (i_acc[ACC_BITS-1]) begin
            o_val = W_MIN;
        end else begin
            o_val = W_MAX;
        end
    end

endmodule

FILE: hdl/matrix4_row_multiply_unit.sv
// 4x4 matrix row multiplier, signed fixed point (Q16.16 by default).
// Input channel (i_valid / o_ready): each beat carries i_action, i_row_sel
// and four row elements. A load beat (action 0) writes row i_row_sel of the
// stored matrix B and produces no result. A multiply beat (action 1) carries
// one row a of A and produces one result beat: out_j = sum_k a_k * B[k][j],
// shifted right arithmetically by FRAC_BITS and clamped to WORD_BITS signed,
// with o_saturated set if any lane clamped.
// Output channel (o_valid / i_ready): one registered result per multiply.
// Throughput: one beat per cycle while the receiver does not stall, loads and
// multiplies freely mixed; a load takes effect for every multiply accepted after it.
// Path: a multiply passes through four cells of multiply + accumulate
// stages, the last stage of the last cell feeding the output register.
// The chain holds four cells, one per row of B.
// Reset (synchronous, active low): B is cleared to zero, the pipeline empties.
// Receiver stall: while a result waits and i_ready is low, the whole chain
// holds and o_ready drops; it resumes in the cycle the result is taken.
module matrix4_row_multiply_unit #(
    parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m4rm_pkg::WORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic                                     i_action,
    input  logic [m4rm_pkg::ROW_BITS-1:0]            i_row_sel,
    input  logic signed [m4rm_pkg::FIELD_BITS-1:0]   i_in_0,
    input  logic signed [m4rm_pkg::FIELD_BITS-1:0]   i_in_1,
    input  logic signed [m4rm_pkg::FIELD_BITS-1:0]   i_in_2,
    input  logic signed [m4rm_pkg::FIELD_BITS-1:0]   i_in_3,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [m4rm_pkg::FIELD_BITS-1:0]   o_out_0,
    output logic signed [m4rm_pkg::FIELD_BITS-1:0]   o_out_1,
    output logic signed [m4rm_pkg::FIELD_BITS-1:0]   o_out_2,
    output logic signed [m4rm_pkg::FIELD_BITS-1:0]   o_out_3,
    output logic                                     o_saturated
);

    localparam int ACC_BITS = 2 * WORD_BITS + 2;
    localparam int DIM = m4rm_pkg::DIM;
    localparam int FB = m4rm_pkg::FIELD_BITS;

    // Clamp limits as they appear on the ports after sign extension.
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
    localparam logic [FB-1:0] OUT_MAX = FB'(W_MAX);
    localparam logic [FB-1:0] OUT_MIN = FB'(W_MIN);

    // Chain links: index k feeds cell k, index DIM leaves the last cell.
    m4rm_pkg::t_ctrl             w_ctrl [DIM+1];
    logic signed [WORD_BITS-1:0] w_row  [DIM+1][DIM];
    logic signed [ACC_BITS-1:0]  w_sum  [DIM+1][DIM];

    logic signed [WORD_BITS-1:0] w_sat   [DIM];
    logic [DIM-1:0]              w_clamp;
    logic                        w_en;

    logic                        r_out_valid;
    logic signed [WORD_BITS-1:0] r_out [DIM];
    logic                        r_out_sat;

    // Advance the chain whenever the output register is free or being drained.
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // Feed the chain: only the low WORD_BITS of each element take part.
    assign w_ctrl[0] = '{valid:   i_valid,
                         action:  m4rm_pkg::t_action'(i_action),
                         row_sel: i_row_sel};
    assign w_row[0][0] = i_in_0[WORD_BITS-1:0];
    assign w_row[0][1] = i_in_1[WORD_BITS-1:0];
    assign w_row[0][2] = i_in_2[WORD_BITS-1:0];
    assign w_row[0][3] = i_in_3[WORD_BITS-1:0];

    // Partial sums start at zero.
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            w_sum[0][j] = '0;
        end
    end

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        m4rm_cell #(
            .INDEX     (k),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[k]),
            .i_row   (w_row[k]),
            .i_sum   (w_sum[k]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_row   (w_row[k+1]),
            .o_sum   (w_sum[k+1])
        );
    end

    for (genvar j = 0; j < DIM; j++) begin : g_sat
        m4rm_sat #(
            .FRAC_BITS (FRAC_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_sat (
            .i_acc   (w_sum[DIM][j]),
            .o_val   (w_sat[j]),
            .o_clamp (w_clamp[j])
        );
    end

    // Output register: hold while stalled, drop load beats at the chain end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctrl[DIM].valid && (w_ctrl[DIM].action == m4rm_pkg::ACT_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out     <= w_sat;
            r_out_sat <= |w_clamp;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_0     = FB'(r_out[0]);
    assign o_out_1     = FB'(r_out[1]);
    assign o_out_2     = FB'(r_out[2]);
    assign o_out_3     = FB'(r_out[3]);
    assign o_saturated = r_out_sat;

    // A clamped result must carry at least one lane at a range limit.
    a_sat_has_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_0 == OUT_MAX || o_out_0 == OUT_MIN ||
             o_out_1 == OUT_MAX || o_out_1 == OUT_MIN ||
             o_out_2 == OUT_MAX || o_out_2 == OUT_MIN ||
             o_out_3 == OUT_MAX || o_out_3 == OUT_MIN))
        else $error("saturated flag without a clamped lane");

    // A stalled result must freeze the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while result stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // An empty output register never blocks the input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

endmodule

FILE: verif/m4rm_result_check.sv
`timescale 1ns / 1ps

module m4rm_result_check #(
    parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m4rm_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [1:0]  i_row_sel,
    input  logic [31:0] i_in_0,
    input  logic [31:0] i_in_1,
    input  logic [31:0] i_in_2,
    input  logic [31:0] i_in_3,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_0,
    input  logic [31:0] i_out_1,
    input  logic [31:0] i_out_2,
    input  logic [31:0] i_out_3,
    input  logic        i_out_sat,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0][31:0] lane;
        logic             sat;
    } t_row_result;

    logic [31:0] b_words [16];
    t_row_result expected_rows [$];
    int          errs = 0;

    // Take the low WORD_BITS bits as a two's complement number.
    function automatic logic signed [31:0] word_sext(input logic [31:0] v);
        logic [31:0] up;
        up = v << (32 - WORD_BITS);
        return $signed(up) >>> (32 - WORD_BITS);
    endfunction

    // One result row: full-precision dot products, floor shift, clamp.
    function automatic t_row_result row_product(input logic [3:0][31:0] a);
        t_row_result        r;
        logic signed [66:0] acc;
        logic signed [63:0] prod;
        logic signed [66:0] hi_lim;
        logic signed [66:0] lo_lim;
        int                 j;
        int                 k;
        hi_lim = (67'sd1 <<< (WORD_BITS - 1)) - 67'sd1;
        lo_lim = -(67'sd1 <<< (WORD_BITS - 1));
        r.sat  = 1'b0;
        for (j = 0; j < m4rm_pkg::DIM; j++) begin
            acc = '0;
            for (k = 0; k < m4rm_pkg::DIM; k++) begin
                prod = word_sext(a[k]) * word_sext(b_words[k*m4rm_pkg::DIM + j]);
                acc  = acc + prod;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > hi_lim) begin
                r.lane[j] = hi_lim[31:0];
                r.sat     = 1'b1;
            end else if (acc < lo_lim) begin
                r.lane[j] = lo_lim[31:0];
                r.sat     = 1'b1;
            end else begin
                r.lane[j] = acc[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_row_result got;
        t_row_result want;
        int          k;
        if (!i_rst_n) begin
            for (k = 0; k < 16; k++) b_words[k] = '0;
            expected_rows.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_out_3, i_out_2, i_out_1, i_out_0, i_out_sat};
                if (expected_rows.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result beat: %h %h %h %h sat %b",
                                 i_out_0, i_out_1, i_out_2, i_out_3, i_out_sat);
                end else begin
                    want = expected_rows.pop_front();
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10)
                            $display({"row mismatch: exp %h %h %h %h sat %b,",
                                      " got %h %h %h %h sat %b"},
                                     want.lane[0], want.lane[1], want.lane[2], want.lane[3],
                                     want.sat, got.lane[0], got.lane[1], got.lane[2],
                                     got.lane[3], got.sat);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == m4rm_pkg::ACT_MUL) begin
                    expected_rows.push_back(row_product({i_in_3, i_in_2, i_in_1, i_in_0}));
                end else begin
                    b_words[i_row_sel*m4rm_pkg::DIM + 0] = i_in_0;
                    b_words[i_row_sel*m4rm_pkg::DIM + 1] = i_in_1;
                    b_words[i_row_sel*m4rm_pkg::DIM + 2] = i_in_2;
                    b_words[i_row_sel*m4rm_pkg::DIM + 3] = i_in_3;
                end
            end
        end
        o_fail_count <= errs;
        o_pending    <= expected_rows.size();
    end

endmodule

FILE: verif/matrix4_row_multiply_unit_tb.sv
`timescale 1ns / 1ps

module matrix4_row_multiply_unit_tb;

    localparam int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF;
    localparam int WORD_BITS = m4rm_pkg::WORD_BITS_DEF;

    // Handy Q16.16 words for the directed part.
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_LSB  = 32'h0000_0001;
    localparam logic [31:0] Q_NLSB = 32'hFFFF_FFFF;

    localparam int RANDOM_ROWS  = 400;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_action  = 1'b0;
    logic [1:0]  i_row_sel = '0;
    logic [31:0] i_in_0    = '0;
    logic [31:0] i_in_1    = '0;
    logic [31:0] i_in_2    = '0;
    logic [31:0] i_in_3    = '0;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_out_0;
    logic [31:0] o_out_1;
    logic [31:0] o_out_2;
    logic [31:0] o_out_3;
    logic        o_saturated;

    int fail_count;
    int rows_pending;

    // Pacing controls for the two drivers.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hold_go = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    matrix4_row_multiply_unit #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_row_sel   (i_row_sel),
        .i_in_0      (i_in_0),
        .i_in_1      (i_in_1),
        .i_in_2      (i_in_2),
        .i_in_3      (i_in_3),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_0     (o_out_0),
        .o_out_1     (o_out_1),
        .o_out_2     (o_out_2),
        .o_out_3     (o_out_3),
        .o_saturated (o_saturated)
    );

    m4rm_result_check #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_action     (i_action),
        .i_row_sel    (i_row_sel),
        .i_in_0       (i_in_0),
        .i_in_1       (i_in_1),
        .i_in_2       (i_in_2),
        .i_in_3       (i_in_3),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_0      (o_out_0),
        .i_out_1      (o_out_1),
        .i_out_2      (o_out_2),
        .i_out_3      (o_out_3),
        .i_out_sat    (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (rows_pending)
    );

    // Offer one beat: idle a random number of cycles first (unless calm),
    // then hold valid and payload until the block takes the beat.
    task automatic send_row(input m4rm_pkg::t_action act, input logic [1:0] row,
                            input logic [31:0] e0, input logic [31:0] e1,
                            input logic [31:0] e2, input logic [31:0] e3);
        if (!tx_calm) begin
            while ($urandom_range(99) < 15) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_row_sel <= row;
        i_in_0    <= e0;
        i_in_1    <= e1;
        i_in_2    <= e2;
        i_in_3    <= e3;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Load all four rows of B with the same row.
    task automatic load_all_rows(input logic [31:0] e0, input logic [31:0] e1,
                                 input logic [31:0] e2, input logic [31:0] e3);
        int r;
        for (r = 0; r < m4rm_pkg::DIM; r++) begin
            send_row(m4rm_pkg::ACT_LOAD, r[1:0], e0, e1, e2, e3);
        end
    endtask

    // Wait until every expected row has come back, then let the pipe settle.
    task automatic drain_results();
        do @(posedge i_clk); while (rows_pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Mix of element values: full random words (saturate often), small
    // fixed-point values (land in range), wider values up to +/-256, and the corner words.
    function automatic logic [31:0] pick_elem();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom;
            3, 4, 5: v = $urandom_range(32'h0008_0000) - 32'h0004_0000;
            6: begin
                case ($urandom_range(6))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = Q_NLSB;
                    4: v = Q_LSB;
                    5: v = Q_ONE;
                    default: v = Q_MONE;
                endcase
            end
            default: v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
        endcase
        return v;
    endfunction

    task automatic send_random_row(input int load_pct);
        m4rm_pkg::t_action act;
        act = ($urandom_range(99) < load_pct) ? m4rm_pkg::ACT_LOAD : m4rm_pkg::ACT_MUL;
        send_row(act, 2'($urandom_range(3)), pick_elem(), pick_elem(),
                 pick_elem(), pick_elem());
    endtask

    // Receiver: random ready, a long hold-off on request, steady when calm.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_go) begin
                rx_hold_go = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog: end the run at a hard cycle limit.
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Multiply against B straight out of reset: all zeros.
        send_row(m4rm_pkg::ACT_MUL, 2'd3, Q_MAX, Q_MIN, Q_NLSB, Q_LSB);

        // Identity in Q16.16: the row must come back unchanged.
        send_row(m4rm_pkg::ACT_LOAD, 2'd0, Q_ONE, '0, '0, '0);
        send_row(m4rm_pkg::ACT_LOAD, 2'd1, '0, Q_ONE, '0, '0);
        send_row(m4rm_pkg::ACT_LOAD, 2'd2, '0, '0, Q_ONE, '0);
        send_row(m4rm_pkg::ACT_LOAD, 2'd3, '0, '0, '0, Q_ONE);
        send_row(m4rm_pkg::ACT_MUL, 2'd0, Q_MAX, Q_MIN, Q_NLSB, Q_LSB);
        send_row(m4rm_pkg::ACT_MUL, 2'd2, '0, '0, '0, '0);

        // Corner words in every row of B: lanes 0 and 1 overflow both ways,
        // lanes 2 and 3 shift tiny products, negative ones round down.
        load_all_rows(Q_MAX, Q_MIN, Q_LSB, Q_NLSB);
        send_row(m4rm_pkg::ACT_MUL, 2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_row(m4rm_pkg::ACT_MUL, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_row(m4rm_pkg::ACT_MUL, 2'd3, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_row(m4rm_pkg::ACT_MUL, 2'd2, Q_NLSB, '0, '0, '0);
        send_row(m4rm_pkg::ACT_MUL, 2'd1, Q_LSB, Q_NLSB, Q_ONE, Q_MONE);

        // Reload one row only; the other three keep the corner words.
        send_row(m4rm_pkg::ACT_LOAD, 2'd2, Q_MONE, Q_ONE, Q_MONE, Q_ONE);
        send_row(m4rm_pkg::ACT_MUL, 2'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_row(m4rm_pkg::ACT_MUL, 2'd3, '0, '0, Q_MAX, '0);

        // Random rows, first third.
        for (n = 0; n < RANDOM_ROWS / 3; n++) send_random_row(30);

        // Back-pressure: stop the receiver for a long stretch while the
        // sender keeps offering multiplies, so the pipe fills and stalls.
        rx_hold_go = 1'b1;
        tx_calm    = 1'b1;
        for (n = 0; n < 40; n++) send_random_row(0);
        tx_calm    = 1'b0;

        // Pause the sender until every row is back.
        i_valid <= 1'b0;
        drain_results();

        // A stretch with no idling on either side.
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        for (n = 0; n < 60; n++) send_random_row(30);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Random rows, the rest.
        for (n = 0; n < RANDOM_ROWS - RANDOM_ROWS / 3 - 100; n++) send_random_row(30);

        i_valid <= 1'b0;
        drain_results();

        if (fail_count == 0 && rows_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/m4rm_pkg.sv
hdl/m4rm_cell.sv
hdl/m4rm_sat.sv
hdl/matrix4_row_multiply_unit.sv
verif/m4rm_result_check.sv
verif/matrix4_row_multiply_unit_tb.sv
